@@ hdl/htpd_pkg.sv @@
// shared types and constants for the header/trailer packet deframer
package htpd_pkg;

	// frame geometry
	localparam int PAYLOAD_BYTES = 8;
	localparam int STORE_BYTES   = 8;
	localparam int INDEX_W       = 4;
	localparam int STORE_IDX_W   = $clog2(STORE_BYTES);

	// configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_HEADER  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TRAILER = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WRAP    = 2'd2;

	// configuration reset values
	localparam logic [7:0]  HEADER_RESET  = 8'hFF;
	localparam logic [7:0]  TRAILER_RESET = 8'hFE;
	localparam logic [15:0] WRAP_RESET    = 16'd10000;

	// request command codes
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	// receive phase
	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_TRAILER = 2'd2
	} phase_t;

	// configuration register set
	typedef struct packed {
		logic [7:0]  header_byte;
		logic [7:0]  trailer_byte;
		logic [15:0] count_wrap;
	} cfg_t;

	// input request
	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} req_t;

	// result
	typedef struct packed {
		logic        flag_seen;
		logic [63:0] payload;
		logic [1:0]  receive_phase;
		logic [15:0] byte_count;
	} res_t;

endpackage

@@ hdl/htpd_cfg.sv @@
// configuration registers of the deframer
module htpd_cfg
	import htpd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	// register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte  <= HEADER_RESET;
			cfg_q.trailer_byte <= TRAILER_RESET;
			cfg_q.count_wrap   <= WRAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER: begin
					cfg_q.header_byte <= cfg_data[7:0];
				end
				REG_TRAILER: begin
					cfg_q.trailer_byte <= cfg_data[7:0];
				end
				REG_WRAP: begin
					cfg_q.count_wrap <= cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/htpd_core.sv @@
// frame state, payload store and byte counter with next-result logic
module htpd_core
	import htpd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  req_t req,
	input  cfg_t cfg,
	output res_t res_next
);

	phase_t                   phase_q, phase_d;
	logic [INDEX_W-1:0]       index_q, index_d;
	logic [STORE_BYTES-1:0][7:0] store_q, store_d;
	logic                     ready_q, ready_d;
	logic [15:0]              count_q, count_d;
	logic [15:0]              count_inc;
	logic                     seen;
	logic [INDEX_W-1:0]       index_inc;
	logic [63:0]              packed_payload;

	// next state for one request
	always_comb begin
		phase_d   = phase_q;
		index_d   = index_q;
		store_d   = store_q;
		ready_d   = ready_q;
		count_d   = count_q;
		seen      = 1'b0;
		count_inc = count_q + 16'd1;
		index_inc = index_q + INDEX_W'(1);
		if (req.cmd == CMD_POLL) begin
			seen    = ready_q;
			ready_d = 1'b0;
		end else begin
			// counter wraps only on an exact match
			count_d = (count_inc == cfg.count_wrap) ? 16'd0 : count_inc;
			case (phase_q)
				PH_PAYLOAD: begin
					store_d[index_q[STORE_IDX_W-1:0]] = req.rx_byte;
					index_d = index_inc;
					if (index_inc >= INDEX_W'(PAYLOAD_BYTES)) begin
						phase_d = PH_TRAILER;
					end
				end
				PH_TRAILER: begin
					if (req.rx_byte == cfg.trailer_byte) begin
						phase_d = PH_HEADER;
						ready_d = 1'b1;
					end
				end
				default: begin
					if (req.rx_byte == cfg.header_byte) begin
						phase_d = PH_PAYLOAD;
						index_d = '0;
					end
				end
			endcase
		end
	end

	// pack the visible payload bytes
	always_comb begin
		packed_payload = '0;
		for (int k = 0; k < STORE_BYTES; k++) begin
			if (k < PAYLOAD_BYTES) begin
				packed_payload[8*k +: 8] = store_d[k];
			end
		end
	end

	// result after this request
	assign res_next.flag_seen     = seen;
	assign res_next.payload       = packed_payload;
	assign res_next.receive_phase = phase_d;
	assign res_next.byte_count    = count_d;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			index_q <= '0;
			store_q <= '0;
			ready_q <= 1'b0;
			count_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			index_q <= index_d;
			store_q <= store_d;
			ready_q <= ready_d;
			count_q <= count_d;
		end
	end

endmodule

@@ hdl/header_trailer_packet_deframer.sv @@
// top level of the header/trailer packet deframer
// Takes one request per clock while cmd_stall is low: a received byte or a
// poll of the frame-ready flag. Each request gives exactly one result in the
// cycle after it is taken, held in an output register; a new request is
// taken in the same cycle the waiting result is taken, so the sustained rate
// is one request per clock and cmd_stall rises only while a result sits
// unclaimed under res_stall. The frame state, payload store and counter
// update in a single pass of compare and select logic. Configuration writes
// take effect on the next clock and belong in idle periods.
module header_trailer_packet_deframer
	import htpd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  req_t                   cmd_req,
	output logic                   res_valid,
	input  logic                   res_stall,
	output res_t                   res_req
);

	cfg_t cfg;
	res_t res_next;
	res_t res_q;
	logic res_valid_q;
	logic take;

	// configuration registers
	htpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake: take a request when the result register is free or draining
	assign cmd_stall = res_valid_q && res_stall;
	assign take      = cmd_valid && !cmd_stall;

	// frame logic
	htpd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.req      (cmd_req),
		.cfg      (cfg),
		.res_next (res_next)
	);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_req   = res_q;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the header/trailer packet deframer
module tb_top;
	import htpd_pkg::*;

	localparam int IDLE_LIMIT     = 2000;
	localparam int NUM_SETS       = 6;
	localparam int RANDOM_PER_SET = 235;
	localparam res_t NO_RES       = '0;

	// one request with an optional hand-typed result
	typedef struct packed {
		logic fixed;
		req_t req;
		res_t want;
	} rx_entry_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   cmd_valid = 1'b0;
	req_t                   cmd_req   = '0;
	logic                   res_stall = 1'b0;
	logic                   cmd_stall;
	logic                   res_valid;
	res_t                   res_req;

	// shadow of the deframer state and registers
	logic [7:0]         hdr_val;
	logic [7:0]         trl_val;
	logic [15:0]        wrap_val;
	phase_t             rx_phase;
	logic [INDEX_W-1:0] pay_idx;
	logic [63:0]        pay_bytes;
	logic               frm_ready;
	logic [15:0]        rx_count;

	rx_entry_t stim_q[$];
	rx_entry_t cur_entry = '0;
	res_t      frame_result_q[$];
	res_t      predicted;

	int send_gap   = 0;
	int recv_stall = 0;
	int quiet      = 0;
	int errors     = 0;
	int checked    = 0;
	int accepted   = 0;
	int polls      = 0;
	int frames_done = 0;
	int flags_hit  = 0;

	// directed requests under the reset register values
	rx_entry_t directed_tab [0:26] = '{
		{1'b1, CMD_POLL, 8'h00, 1'b0, 64'h0, PH_HEADER, 16'd0},
		{1'b1, CMD_BYTE, 8'h00, 1'b0, 64'h0, PH_HEADER, 16'd1},
		{1'b1, CMD_BYTE, 8'hFE, 1'b0, 64'h0, PH_HEADER, 16'd2},
		{1'b1, CMD_BYTE, 8'hFF, 1'b0, 64'h0, PH_PAYLOAD, 16'd3},
		// header and trailer values inside the payload
		{1'b0, CMD_BYTE, 8'hFF, NO_RES},
		{1'b0, CMD_BYTE, 8'hFE, NO_RES},
		{1'b0, CMD_BYTE, 8'h00, NO_RES},
		{1'b0, CMD_BYTE, 8'h80, NO_RES},
		{1'b0, CMD_BYTE, 8'h7F, NO_RES},
		{1'b0, CMD_BYTE, 8'h01, NO_RES},
		{1'b0, CMD_BYTE, 8'hAA, NO_RES},
		{1'b0, CMD_BYTE, 8'h55, NO_RES},
		// header while waiting for the trailer is dropped
		{1'b0, CMD_BYTE, 8'hFF, NO_RES},
		{1'b0, CMD_POLL, 8'hFF, NO_RES},
		{1'b0, CMD_BYTE, 8'hFE, NO_RES},
		// second frame over the unpolled one
		{1'b0, CMD_BYTE, 8'hFF, NO_RES},
		{1'b0, CMD_BYTE, 8'h5A, NO_RES},
		{1'b0, CMD_BYTE, 8'hC3, NO_RES},
		{1'b0, CMD_BYTE, 8'h3C, NO_RES},
		{1'b0, CMD_BYTE, 8'h0F, NO_RES},
		{1'b0, CMD_BYTE, 8'hF0, NO_RES},
		{1'b0, CMD_BYTE, 8'h96, NO_RES},
		{1'b0, CMD_BYTE, 8'h69, NO_RES},
		{1'b0, CMD_BYTE, 8'hE7, NO_RES},
		// trailer with the flag already set, then two polls
		{1'b0, CMD_BYTE, 8'hFE, NO_RES},
		{1'b0, CMD_POLL, 8'h00, NO_RES},
		{1'b0, CMD_POLL, 8'hA5, NO_RES}
	};

	header_trailer_packet_deframer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_req   (cmd_req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_req   (res_req)
	);

	always #1 clk = ~clk;

	// next result of the deframer for one request
	function automatic res_t deframe_step(req_t r);
		res_t o;
		o = '0;
		if (r.cmd == CMD_POLL) begin
			o.flag_seen = frm_ready;
			if (frm_ready)
				flags_hit++;
			frm_ready = 1'b0;
		end else begin
			rx_count = rx_count + 16'd1;
			if (rx_count == wrap_val)
				rx_count = '0;
			case (rx_phase)
				PH_PAYLOAD: begin
					pay_bytes[pay_idx[2:0]*8 +: 8] = r.rx_byte;
					pay_idx = pay_idx + 1'b1;
					if (pay_idx >= PAYLOAD_BYTES)
						rx_phase = PH_TRAILER;
				end
				PH_TRAILER: begin
					if (r.rx_byte == trl_val) begin
						rx_phase  = PH_HEADER;
						frm_ready = 1'b1;
						frames_done++;
					end
				end
				default: begin
					if (r.rx_byte == hdr_val) begin
						rx_phase = PH_PAYLOAD;
						pay_idx  = '0;
					end
				end
			endcase
		end
		o.payload       = pay_bytes;
		o.receive_phase = rx_phase;
		o.byte_count    = rx_count;
		return o;
	endfunction

	// compare one result with the oldest expected one
	task automatic check_result(res_t got);
		res_t want;
		checked++;
		if (frame_result_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("ERROR: result %h with nothing expected", got);
		end else begin
			want = frame_result_q.pop_front();
			if (got.flag_seen !== want.flag_seen || got.payload !== want.payload ||
					got.receive_phase !== want.receive_phase ||
					got.byte_count !== want.byte_count) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: result %0d exp/got flag %b/%b payload %h/%h phase %0d/%0d count %0d/%0d",
						checked, want.flag_seen, got.flag_seen, want.payload, got.payload,
						want.receive_phase, got.receive_phase, want.byte_count, got.byte_count);
			end
		end
	endtask

	// request and result monitor with the handshake watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				predicted = deframe_step(cmd_req);
				frame_result_q.push_back(cur_entry.fixed ? cur_entry.want : predicted);
				accepted++;
				if (cmd_req.cmd == CMD_POLL)
					polls++;
			end
			if (res_valid && !res_stall) begin
				check_result(res_req);
			end
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= IDLE_LIMIT) begin
				$display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
				$display("** header_trailer_packet_deframer: FAILED **");
				$finish;
			end
		end
	end

	// result-side back-pressure
	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < recv_stall);
	end

	// register write, mirrored into the shadow copy
	task automatic cfg_write(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (index)
			REG_HEADER:  hdr_val  = data[7:0];
			REG_TRAILER: trl_val  = data[7:0];
			REG_WRAP:    wrap_val = data;
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic [7:0] h, logic [7:0] t, logic [15:0] w);
		cfg_write(REG_HEADER, {8'h00, h});
		cfg_write(REG_TRAILER, {8'h00, t});
		cfg_write(REG_WRAP, w);
	endtask

	task automatic add_poll();
		stim_q.push_back({1'b0, CMD_POLL, 8'($urandom_range(255)), NO_RES});
	endtask

	// byte request, sometimes followed by a poll
	task automatic add_byte(logic [7:0] b);
		stim_q.push_back({1'b0, CMD_BYTE, b, NO_RES});
		if ($urandom_range(99) < 8)
			add_poll();
	endtask

	// random byte leaning toward the header and trailer values
	function automatic logic [7:0] pick_byte();
		int k;
		k = $urandom_range(9);
		if (k == 0)
			return hdr_val;
		else if (k == 1)
			return trl_val;
		return 8'($urandom_range(255));
	endfunction

	// mostly whole frames, plus noise, cut-off frames and bare polls
	task automatic build_random(int n);
		int start;
		int kind;
		start = stim_q.size();
		while (stim_q.size() - start < n) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				add_byte(hdr_val);
				repeat (PAYLOAD_BYTES) add_byte(pick_byte());
				repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
				add_byte(trl_val);
			end else if (kind < 85) begin
				repeat ($urandom_range(1, 4)) add_byte(pick_byte());
			end else if (kind < 93) begin
				add_byte(hdr_val);
				repeat ($urandom_range(7)) add_byte(pick_byte());
			end else begin
				add_poll();
			end
		end
	endtask

	// request driver with random gaps; payload held while stalled
	task automatic drive_requests();
		rx_entry_t e;
		@(negedge clk);
		while (stim_q.size() != 0) begin
			e = stim_q.pop_front();
			while ($urandom_range(99) < send_gap) begin
				cmd_valid <= 1'b0;
				@(negedge clk);
			end
			cmd_valid <= 1'b1;
			cmd_req   <= e.req;
			cur_entry <= e;
			@(posedge clk);
			while (cmd_stall)
				@(posedge clk);
			@(negedge clk);
		end
		cmd_valid <= 1'b0;
	endtask

	initial begin
		int set;
		hdr_val   = HEADER_RESET;
		trl_val   = TRAILER_RESET;
		wrap_val  = WRAP_RESET;
		rx_phase  = PH_HEADER;
		pay_idx   = '0;
		pay_bytes = '0;
		frm_ready = 1'b0;
		rx_count  = '0;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		for (set = 0; set < NUM_SETS; set++) begin
			// receiver-heavy stalls, then sender-heavy gaps, then full rate
			case (set / 2)
				0: begin
					send_gap   = 28;
					recv_stall = 63;
				end
				1: begin
					send_gap   = 63;
					recv_stall = 28;
				end
				default: begin
					send_gap   = 0;
					recv_stall = 0;
				end
			endcase
			// register extremes; a wrap of one with the counter already above it
			case (set)
				0: begin
					foreach (directed_tab[i])
						stim_q.push_back(directed_tab[i]);
				end
				1: apply_settings(8'h00, 8'hFF, 16'd1);
				2: apply_settings(8'hA5, 8'h5A, 16'd7);
				3: apply_settings(8'hFF, 8'h00, 16'hFFFF);
				// same value opens and closes; counter left above the wrap
				4: apply_settings(8'h3C, 8'h3C, 16'd20);
				default: apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
					16'($urandom_range(2, 300)));
			endcase
			build_random(RANDOM_PER_SET);
			drive_requests();
			while (frame_result_q.size() != 0)
				@(posedge clk);
			repeat (4) @(negedge clk);
		end

		errors += frame_result_q.size();
		$display("%0d requests (%0d polls) across %0d register settings, %0d results checked",
			accepted, polls, NUM_SETS, checked);
		$display("%0d frames closed by a trailer, %0d polls found a ready frame, %0d mismatches",
			frames_done, flags_hit, errors);
		if (errors == 0) begin
			$display("** header_trailer_packet_deframer: PASSED **");
		end else begin
			$display("** header_trailer_packet_deframer: FAILED **");
		end
		$finish;
	end

endmodule
